// ===== sv/bir_pkg.sv =====
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types and constants of the bicubic image resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bir_pkg;

   localparam int PIX_W      = 16;
   localparam int COORD_W    = 7;
   localparam int BAND_W     = 2;
   localparam int FRAC_IN_W  = 8;
   localparam int SIZE_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CNT_W      = 5;

   typedef enum logic [0:0] {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_OUTPUT   = 2'd2;

   localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 8'd128;
   localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 8'd128;
   localparam logic [PIX_W-1:0]  RST_MAX_OUTPUT   = 16'd1023;

   // fetch schedule: reads 0..15, window shifts 1..16, row passes start at 4, 8, 12 and 16
   localparam logic [CNT_W-1:0] CNT_LAST_READ  = 5'd15;
   localparam logic [CNT_W-1:0] CNT_LAST_SHIFT = 5'd16;
   localparam logic [CNT_W-1:0] CNT_FIRST_CAP  = 5'd8;
   localparam logic [CNT_W-1:0] CNT_START_V    = 5'd20;
   localparam logic [CNT_W-1:0] CNT_LAST       = 5'd23;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_PREP,
      ST_FETCH,
      ST_FINISH
   } bir_state_type;

   typedef struct packed {
      logic       latch;
      logic       write;
      logic       prep;
      logic       rd_en;
      logic [3:0] tap;
      logic       shift;
      logic       start_h;
      logic       cap_h;
      logic       start_v;
      logic       load_out;
   } bir_cmd_type;

   typedef struct packed {
      logic req_query;
      logic req_band_ok;
      logic out_free;
   } bir_sts_type;

endpackage

// ===== sv/bir_req_if.sv =====
// ----------------------------------------------------------------------------
// bir_req_if
// Request channel: load or query transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bir_req_if;
   import bir_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [BAND_W-1:0]    band;
   logic [COORD_W-1:0]   col;
   logic [COORD_W-1:0]   row;
   logic [PIX_W-1:0]     pixel;
   logic [FRAC_IN_W-1:0] frac_x;
   logic [FRAC_IN_W-1:0] frac_y;

   modport source (output valid, kind, band, col, row, pixel, frac_x, frac_y, input ready);
   modport sink   (input valid, kind, band, col, row, pixel, frac_x, frac_y, output ready);
endinterface

// ===== sv/bir_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bir_rsp_if
// Response channel: one interpolated value per query transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bir_rsp_if;
   import bir_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] value;

   modport source (output valid, value, input ready);
   modport sink   (input valid, value, output ready);
endinterface

// ===== sv/bir_csr_if.sv =====
// ----------------------------------------------------------------------------
// bir_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bir_csr_if;
   import bir_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/bir_cubic.sv =====
// ----------------------------------------------------------------------------
// bir_cubic
// Shared cubic convolution unit: one pass over four samples, Horner steps
// through one multiplier with registered operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bir_cubic #(
   parameter int DW        = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [DW-1:0] p0,
   input  logic signed [DW-1:0] p1,
   input  logic signed [DW-1:0] p2,
   input  logic signed [DW-1:0] p3,
   input  logic [FRAC_BITS-1:0] d,
   output logic                 busy,
   output logic signed [DW-1:0] result
);
   localparam int PW = DW + FRAC_BITS + 1;
   localparam logic signed [PW-1:0] RND = PW'(1) <<< (FRAC_BITS - 1);

   logic signed [DW-1:0]  b1;
   logic signed [DW-1:0]  b2;
   logic signed [DW-1:0]  b3;
   logic signed [DW-1:0]  diff12;
   logic signed [PW-1:0]  prod;
   logic signed [PW-1:0]  rounded;
   logic signed [DW-1:0]  step_val;
   logic signed [DW-1:0]  half;
   logic signed [DW-1:0]  s_ff;
   logic signed [DW-1:0]  k1_ff;
   logic signed [DW-1:0]  k2_ff;
   logic signed [DW-1:0]  p1_ff;
   logic [FRAC_BITS-1:0]  d_ff;
   logic [1:0]            cnt_ff;
   logic [1:0]            cnt_in;

   always_comb begin
      diff12 = p1 - p2;
      b1     = p2 - p0;
      b2     = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
      b3     = (diff12 <<< 1) + diff12 + p3 - p0;
   end

   always_comb begin
      prod     = s_ff * $signed({1'b0, d_ff});
      rounded  = (prod + RND) >>> FRAC_BITS;
      step_val = DW'(rounded) + k1_ff;
      half     = (s_ff + DW'(1)) >>> 1;
      result   = p1_ff + half;
      busy     = (cnt_ff != 2'd0);
   end

   always_comb begin
      if (start) begin
         cnt_in = 2'd3;
      end else if (busy) begin
         cnt_in = cnt_ff - 2'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         s_ff  <= b3;
         k1_ff <= b2;
         k2_ff <= b1;
         p1_ff <= p1;
         d_ff  <= d;
      end else if (busy) begin
         s_ff  <= step_val;
         k1_ff <= k2_ff;
         k2_ff <= '0;
      end
   end
endmodule

// ===== sv/bir_datapath.sv =====
// ----------------------------------------------------------------------------
// bir_datapath
// Image memory, register file, neighbour addressing, sample window,
// shared cubic unit and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bir_datapath #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int NUM_BANDS  = 4,
   parameter int FRAC_BITS  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bir_pkg::bir_cmd_type cmd,
   output bir_pkg::bir_sts_type sts,
   bir_req_if.sink              req_bus,
   bir_rsp_if.source            rsp_bus,
   bir_csr_if.sink              csr_bus
);
   import bir_pkg::*;

   localparam int DEPTH = NUM_BANDS * MAX_HEIGHT * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int LW    = 14;
   localparam int DW    = PIX_W + FRAC_BITS + 8;
   localparam logic signed [DW-1:0] RND = DW'(1) <<< (FRAC_BITS - 1);

   function automatic logic signed [LW-1:0] clamp_coord(
      input logic signed [LW-1:0] c,
      input logic signed [LW-1:0] size
   );
      logic signed [LW-1:0] res;
      if (c < 0) begin
         res = '0;
      end else if (c >= size) begin
         res = size - LW'(1);
      end else begin
         res = c;
      end
      return res;
   endfunction

   function automatic logic signed [DW-1:0] pix_to_q(input logic [PIX_W-1:0] pix);
      logic signed [DW-1:0] q;
      q = $signed({{(DW - PIX_W){1'b0}}, pix}) <<< FRAC_BITS;
      return q;
   endfunction

   logic [SIZE_W-1:0]     width_ff;
   logic [SIZE_W-1:0]     height_ff;
   logic [PIX_W-1:0]      maxout_ff;

   logic [BAND_W-1:0]     band_ff;
   logic [COORD_W-1:0]    col_ff;
   logic [COORD_W-1:0]    row_ff;
   logic [PIX_W-1:0]      pixel_ff;
   logic [FRAC_BITS-1:0]  dx_ff;
   logic [FRAC_BITS-1:0]  dy_ff;
   logic                  band_ok_ff;
   logic                  load_ok_ff;
   logic                  req_band_ok;
   logic                  req_load_ok;

   logic signed [LW-1:0]  w_eff;
   logic signed [LW-1:0]  h_eff;
   logic signed [LW-1:0]  col_s [4];
   logic signed [LW-1:0]  row_s [4];
   logic [CW-1:0]         col_c_ff [4];
   logic [AW-1:0]         row_off_ff [4];

   logic [PIX_W-1:0]      mem [DEPTH];
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         mem_addr;
   logic [PIX_W-1:0]      rdata_ff;

   logic [PIX_W-1:0]      win_ff [3];
   logic signed [DW-1:0]  hr_ff [3];

   logic                  cub_start;
   logic signed [DW-1:0]  cub_p0;
   logic signed [DW-1:0]  cub_p1;
   logic signed [DW-1:0]  cub_p2;
   logic signed [DW-1:0]  cub_p3;
   logic [FRAC_BITS-1:0]  cub_d;
   logic                  cub_busy;
   logic signed [DW-1:0]  cub_res;

   logic signed [DW-1:0]  limit;
   logic signed [DW-1:0]  rnd_v;
   logic [PIX_W-1:0]      out_val;
   logic                  rsp_valid_ff;
   logic [PIX_W-1:0]      value_ff;

   // register file
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         maxout_ff <= RST_MAX_OUTPUT;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_bus.data[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_bus.data[SIZE_W-1:0];
            CSR_MAX_OUTPUT:   maxout_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // request capture
   always_comb begin
      req_band_ok = (32'(req_bus.band) < NUM_BANDS);
      req_load_ok = req_band_ok && (32'(req_bus.col) < MAX_WIDTH)
                    && (32'(req_bus.row) < MAX_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         band_ff    <= req_bus.band;
         col_ff     <= req_bus.col;
         row_ff     <= req_bus.row;
         pixel_ff   <= req_bus.pixel;
         dx_ff      <= FRAC_BITS'(req_bus.frac_x);
         dy_ff      <= FRAC_BITS'(req_bus.frac_y);
         band_ok_ff <= req_band_ok;
         load_ok_ff <= req_load_ok;
      end
   end

   // neighbour coordinates
   always_comb begin
      if (width_ff == '0) begin
         w_eff = LW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = LW'(MAX_WIDTH);
      end else begin
         w_eff = LW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = LW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = LW'(MAX_HEIGHT);
      end else begin
         h_eff = LW'(height_ff);
      end
      for (int k = 0; k < 4; k++) begin
         col_s[k] = clamp_coord($signed({{(LW - COORD_W){1'b0}}, col_ff}) + LW'(k - 1), w_eff);
         row_s[k] = clamp_coord($signed({{(LW - COORD_W){1'b0}}, row_ff}) + LW'(k - 1), h_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         for (int k = 0; k < 4; k++) begin
            col_c_ff[k]   <= CW'(col_s[k]);
            row_off_ff[k] <= AW'((32'(band_ff) * MAX_HEIGHT + 32'(row_s[k])) * MAX_WIDTH);
         end
      end
   end

   // image memory
   always_comb begin
      wr_addr = AW'((32'(band_ff) * MAX_HEIGHT + 32'(row_ff)) * MAX_WIDTH + 32'(col_ff));
      if (cmd.write) begin
         mem_addr = wr_addr;
      end else begin
         mem_addr = row_off_ff[cmd.tap[3:2]] + AW'(col_c_ff[cmd.tap[1:0]]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && load_ok_ff) begin
         mem[mem_addr] <= pixel_ff;
      end else if (cmd.rd_en) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   // sample window and row results
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= rdata_ff;
      end
      if (cmd.cap_h) begin
         hr_ff[0] <= hr_ff[1];
         hr_ff[1] <= hr_ff[2];
         hr_ff[2] <= cub_res;
      end
   end

   always_comb begin
      cub_start = cmd.start_h || cmd.start_v;
      if (cmd.start_v) begin
         cub_p0 = hr_ff[0];
         cub_p1 = hr_ff[1];
         cub_p2 = hr_ff[2];
         cub_p3 = cub_res;
         cub_d  = dy_ff;
      end else begin
         cub_p0 = pix_to_q(win_ff[0]);
         cub_p1 = pix_to_q(win_ff[1]);
         cub_p2 = pix_to_q(win_ff[2]);
         cub_p3 = pix_to_q(rdata_ff);
         cub_d  = dx_ff;
      end
   end

   bir_cubic #(
      .DW        (DW),
      .FRAC_BITS (FRAC_BITS)
   ) u_cubic (
      .clock  (clock),
      .reset  (reset),
      .start  (cub_start),
      .p0     (cub_p0),
      .p1     (cub_p1),
      .p2     (cub_p2),
      .p3     (cub_p3),
      .d      (cub_d),
      .busy   (cub_busy),
      .result (cub_res)
   );

   // saturation, rounding and output register
   always_comb begin
      limit = $signed({{(DW - PIX_W - FRAC_BITS){1'b0}}, maxout_ff, {FRAC_BITS{1'b0}}});
      rnd_v = (cub_res + RND) >>> FRAC_BITS;
      priority if (!band_ok_ff) begin
         out_val = '0;
      end else if (cub_res < 0) begin
         out_val = '0;
      end else if (cub_res > limit) begin
         out_val = maxout_ff;
      end else begin
         out_val = PIX_W'(rnd_v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         value_ff <= out_val;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.value = value_ff;

   always_comb begin
      sts.req_query   = (req_bus.kind == KIND_QUERY);
      sts.req_band_ok = req_band_ok;
      sts.out_free    = !rsp_valid_ff || rsp_bus.ready;
   end

   a_start_idle_unit: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_h || cmd.start_v) |-> !cub_busy)
      else $error("cubic unit started while busy");

   a_load_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("output register overwritten before transfer");

   a_write_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (!cmd.rd_en && !cmd.start_h && !cmd.start_v))
      else $error("memory write overlaps a fetch");
endmodule

// ===== sv/bir_ctrl.sv =====
// ----------------------------------------------------------------------------
// bir_ctrl
// Controller: accepts transactions and sequences the neighbour fetch, the
// four row passes, the column pass and the result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bir_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bir_pkg::bir_sts_type sts,
   output bir_pkg::bir_cmd_type cmd
);
   import bir_pkg::*;

   bir_state_type    state_ff;
   bir_state_type    state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (!sts.req_query) begin
                  state_in = ST_WRITE;
               end else if (sts.req_band_ok) begin
                  state_in = ST_PREP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_WRITE:  state_in = ST_IDLE;
         ST_PREP:   state_in = ST_FETCH;
         ST_FETCH: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
      cnt_in = ((state_ff == ST_FETCH) && (cnt_ff != CNT_LAST)) ? cnt_ff + CNT_W'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.latch    = accept;
      cmd.write    = (state_ff == ST_WRITE);
      cmd.prep     = (state_ff == ST_PREP);
      cmd.tap      = cnt_ff[3:0];
      cmd.rd_en    = (state_ff == ST_FETCH) && (cnt_ff <= CNT_LAST_READ);
      cmd.shift    = (state_ff == ST_FETCH) && (cnt_ff != '0) && (cnt_ff <= CNT_LAST_SHIFT);
      cmd.start_h  = (state_ff == ST_FETCH) && (cnt_ff[1:0] == 2'd0) && (cnt_ff != '0)
                     && (cnt_ff <= CNT_LAST_SHIFT);
      cmd.cap_h    = (state_ff == ST_FETCH) && (cnt_ff[1:0] == 2'd0)
                     && (cnt_ff >= CNT_FIRST_CAP) && (cnt_ff <= CNT_LAST_SHIFT);
      cmd.start_v  = (state_ff == ST_FETCH) && (cnt_ff == CNT_START_V);
      cmd.load_out = (state_ff == ST_FINISH) && sts.out_free;
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted transaction left no work");

   a_fetch_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH && cnt_ff == CNT_LAST) |=> (state_ff == ST_FINISH))
      else $error("fetch did not end at its last step");

   a_cnt_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_FETCH) |-> (cnt_ff == '0))
      else $error("step counter not cleared outside fetch");
endmodule

// ===== sv/bicubic_image_resampler.sv =====
// ----------------------------------------------------------------------------
// bicubic_image_resampler
// Multi-band image store with Catmull-Rom bicubic sampling. A load transaction
// writes one 16-bit pixel and gives no response. A query transaction passes
// from acceptance through the clamping of the neighbour coordinates, the
// fetch-and-compute steps and the loading of the result into the response
// register, plus any wait for the response channel to drain; a query to a
// band beyond NUM_BANDS skips the fetch and answers 0. The query time is set
// by the sixteen neighbour reads through the single memory port, one per
// cycle, with the shared cubic unit's passes overlapped with the reads, and
// one final column pass. The block works on one transaction at a time; a
// finished response waits in its output register while the next transaction
// is taken. The memory is not cleared after reset: a query must only touch
// pixels that were loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bicubic_image_resampler #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int NUM_BANDS  = 4,
   parameter int FRAC_BITS  = 8
) (
   input  logic       clock,
   input  logic       reset,
   bir_req_if.sink    req_bus,
   bir_rsp_if.source  rsp_bus,
   bir_csr_if.sink    csr_bus
);
   import bir_pkg::*;

   bir_cmd_type cmd;
   bir_sts_type sts;
   logic        ctl_req_ready;

   assign req_bus.ready = ctl_req_ready;

   bir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ctl_req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bir_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .NUM_BANDS  (NUM_BANDS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .sts     (sts),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );
endmodule

// ===== bench/bicubic_image_resampler_tb.sv =====
// ----------------------------------------------------------------------------
// bicubic_image_resampler_tb
// Self-checking bench for the bicubic image resampler. An initial block
// stages load and query transactions phase by phase, under several image
// sizes and saturation limits. Before each query it stages loads for any
// neighbour pixel not yet written. A clocked driver feeds them to the
// request channel, a clocked monitor checks every response against a
// fixed-point Catmull-Rom predictor. Both sides idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bicubic_image_resampler_tb;
   import bir_pkg::*;

   localparam int IMG_MAX      = 128;
   localparam int BAND_WORDS   = IMG_MAX * IMG_MAX;
   localparam int STORE_WORDS  = 4 * BAND_WORDS;
   localparam int FRAC_SHIFT   = 8;
   localparam int SETTLE_CYC   = 40;
   localparam int HOLD_CYC     = 300;
   localparam int QUIET_LIMIT  = 2000;
   localparam int REPORT_MAX   = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      kind_type             kind;
      logic [BAND_W-1:0]    band;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
      logic [PIX_W-1:0]     pixel;
      logic [FRAC_IN_W-1:0] frac_x;
      logic [FRAC_IN_W-1:0] frac_y;
   } pixel_op_type;

   logic clock;
   logic reset;

   bir_req_if req_bus ();
   bir_rsp_if rsp_bus ();
   bir_csr_if csr_bus ();

   bicubic_image_resampler dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pixel_op_type     pending_ops[$];
   logic [PIX_W-1:0] expected_values[$];
   pixel_op_type     cur_op;

   logic [PIX_W-1:0]  model_mem [0:STORE_WORDS-1];
   logic [SIZE_W-1:0] model_width;
   logic [SIZE_W-1:0] model_height;
   logic [PIX_W-1:0]  model_max;

   bit staged [0:STORE_WORDS-1];
   int plan_w;
   int plan_h;
   int ops_staged;

   int req_issued;
   int req_accepts;
   int quiet_cycles;
   int mismatches;
   int send_gap;
   int stall_left;
   int hold_left;
   int hold_asked;
   int hold_served;
   bit no_idle;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int eff_size(input logic [SIZE_W-1:0] size_reg);
      if (size_reg == 0) return 1;
      if (size_reg > IMG_MAX) return IMG_MAX;
      return int'(size_reg);
   endfunction

   function automatic int clamp_coord(input int c, input int size);
      if (c < 0) return 0;
      if (c >= size) return size - 1;
      return c;
   endfunction

   function automatic int store_index(input int band, input int row, input int col);
      return band * BAND_WORDS + row * IMG_MAX + col;
   endfunction

   // floor(x / 2^s + 1/2)
   function automatic longint signed round_q(input longint signed x, input int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint signed cubic_tap(input longint signed p0, input longint signed p1,
                                               input longint signed p2, input longint signed p3,
                                               input longint signed d);
      longint signed b1;
      longint signed b2;
      longint signed b3;
      longint signed acc;
      b1 = p2 - p0;
      b2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      b3 = 3 * (p1 - p2) + p3 - p0;
      acc = round_q(b3 * d, FRAC_SHIFT) + b2;
      acc = round_q(acc * d, FRAC_SHIFT) + b1;
      acc = round_q(acc * d, FRAC_SHIFT);
      return p1 + round_q(acc, 1);
   endfunction

   function automatic logic [PIX_W-1:0] interpolate_value(input pixel_op_type op);
      int w;
      int h;
      int r;
      int c;
      longint signed p[4];
      longint signed hr[4];
      longint signed v;
      longint signed rounded;
      w = eff_size(model_width);
      h = eff_size(model_height);
      for (int i = 0; i < 4; i++) begin
         r = clamp_coord(int'(op.row) + i - 1, h);
         for (int j = 0; j < 4; j++) begin
            c = clamp_coord(int'(op.col) + j - 1, w);
            p[j] = longint'(model_mem[store_index(int'(op.band), r, c)]) <<< FRAC_SHIFT;
         end
         hr[i] = cubic_tap(p[0], p[1], p[2], p[3], longint'(op.frac_x));
      end
      v = cubic_tap(hr[0], hr[1], hr[2], hr[3], longint'(op.frac_y));
      if (v < 0) return '0;
      if (v > (longint'(model_max) <<< FRAC_SHIFT)) return model_max;
      rounded = round_q(v, FRAC_SHIFT);
      return rounded[PIX_W-1:0];
   endfunction

   function automatic logic [PIX_W-1:0] rand_pixel();
      if ($urandom_range(0, 1) == 0) return PIX_W'($urandom_range(0, 1100));
      return PIX_W'($urandom_range(0, 65535));
   endfunction

   task automatic push_load(input int band, input int col, input int row,
                            input logic [PIX_W-1:0] pix);
      pixel_op_type op;
      op.kind   = KIND_LOAD;
      op.band   = BAND_W'(band);
      op.col    = COORD_W'(col);
      op.row    = COORD_W'(row);
      op.pixel  = pix;
      op.frac_x = FRAC_IN_W'($urandom);
      op.frac_y = FRAC_IN_W'($urandom);
      staged[store_index(band, row, col)] = 1'b1;
      pending_ops.push_back(op);
      ops_staged++;
   endtask

   // stage loads for unwritten neighbours, then the query itself
   task automatic push_query(input int band, input int col, input int row,
                             input int fx, input int fy);
      pixel_op_type op;
      int r;
      int c;
      for (int i = 0; i < 4; i++) begin
         r = clamp_coord(row + i - 1, plan_h);
         for (int j = 0; j < 4; j++) begin
            c = clamp_coord(col + j - 1, plan_w);
            if (!staged[store_index(band, r, c)]) push_load(band, c, r, rand_pixel());
         end
      end
      op.kind   = KIND_QUERY;
      op.band   = BAND_W'(band);
      op.col    = COORD_W'(col);
      op.row    = COORD_W'(row);
      op.pixel  = PIX_W'($urandom);
      op.frac_x = FRAC_IN_W'(fx);
      op.frac_y = FRAC_IN_W'(fy);
      pending_ops.push_back(op);
      ops_staged++;
   endtask

   task automatic settle_block();
      while (pending_ops.size() != 0 || req_accepts != req_issued ||
             expected_values.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic apply_setup(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                              input logic [PIX_W-1:0] max_v);
      settle_block();
      csr_write(CSR_IMAGE_WIDTH, {8'($urandom), w});
      csr_write(CSR_IMAGE_HEIGHT, {8'($urandom), h});
      csr_write(CSR_MAX_OUTPUT, max_v);
      plan_w = eff_size(w);
      plan_h = eff_size(h);
   endtask

   task automatic run_phase(input int count, input bit pause_midway);
      int stop_at;
      bit paused;
      stop_at = ops_staged + count;
      paused  = 1'b0;
      while (ops_staged < stop_at) begin
         if (pause_midway && !paused && ops_staged >= stop_at - count / 2) begin
            paused = 1'b1;
            settle_block();
         end
         if ($urandom_range(0, 7) == 0)
            push_load($urandom_range(0, 3), $urandom_range(0, IMG_MAX - 1),
                      $urandom_range(0, IMG_MAX - 1), rand_pixel());
         else
            push_query($urandom_range(0, 3), $urandom_range(0, IMG_MAX - 1),
                       $urandom_range(0, IMG_MAX - 1), $urandom_range(0, 255),
                       $urandom_range(0, 255));
      end
   endtask

   // acceptance: apply loads, predict queries, check responses, apply register writes
   always @(posedge clock) begin
      bit moved;
      logic [PIX_W-1:0] want;
      moved = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            req_accepts++;
            if (cur_op.kind == KIND_LOAD)
               model_mem[store_index(int'(cur_op.band), int'(cur_op.row), int'(cur_op.col))] =
                  cur_op.pixel;
            else
               expected_values.push_back(interpolate_value(cur_op));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (expected_values.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected response: value %0d", rsp_bus.value);
            end else begin
               want = expected_values.pop_front();
               if (rsp_bus.value !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("value mismatch: expected %0d, actual %0d", want, rsp_bus.value);
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            moved = 1'b1;
            unique case (csr_bus.index)
               CSR_IMAGE_WIDTH: begin
                  model_width = csr_bus.data[SIZE_W-1:0];
               end
               CSR_IMAGE_HEIGHT: begin
                  model_height = csr_bus.data[SIZE_W-1:0];
               end
               CSR_MAX_OUTPUT: begin
                  model_max = csr_bus.data;
               end
               default: begin
               end
            endcase
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_accepts == req_issued) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 11) - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            cur_op = pending_ops.pop_front();
            req_bus.kind   <= cur_op.kind;
            req_bus.band   <= cur_op.band;
            req_bus.col    <= cur_op.col;
            req_bus.row    <= cur_op.row;
            req_bus.pixel  <= cur_op.pixel;
            req_bus.frac_x <= cur_op.frac_x;
            req_bus.frac_y <= cur_op.frac_y;
            req_bus.valid  <= 1'b1;
            req_issued++;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response receiver
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left   = HOLD_CYC - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("bicubic_image_resampler test failed");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.kind   = KIND_LOAD;
      req_bus.band   = '0;
      req_bus.col    = '0;
      req_bus.row    = '0;
      req_bus.pixel  = '0;
      req_bus.frac_x = '0;
      req_bus.frac_y = '0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = '0;
      csr_bus.data   = '0;
      model_width    = RST_IMAGE_WIDTH;
      model_height   = RST_IMAGE_HEIGHT;
      model_max      = RST_MAX_OUTPUT;
      plan_w         = eff_size(RST_IMAGE_WIDTH);
      plan_h         = eff_size(RST_IMAGE_HEIGHT);
      for (int k = 0; k < STORE_WORDS; k++) begin
         model_mem[k] = '0;
         staged[k]    = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero-size image: every neighbour folds onto the corner pixel
      apply_setup(8'd0, 8'd0, 16'd65535);
      csr_write(CSR_UNUSED, 16'($urandom));
      push_load(0, 0, 0, 16'hFFFF);
      push_load(1, 0, 0, 16'h0000);
      push_load(3, IMG_MAX - 1, IMG_MAX - 1, 16'h5AA5);
      push_query(0, IMG_MAX - 1, IMG_MAX - 1, 255, 255);
      push_query(1, 64, 0, 0, 255);

      // checkerboard drives over- and undershoot into both clamps
      apply_setup(8'd4, 8'd4, 16'd1023);
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            push_load(0, c, r, ((r + c) % 2 == 1) ? 16'hFFFF : 16'h0000);
      push_query(0, 1, 1, 0, 0);
      push_query(0, 1, 1, 128, 128);
      push_query(0, 2, 1, 255, 0);
      push_query(0, 0, 3, 64, 200);

      apply_setup(8'd4, 8'd4, 16'd1023);
      run_phase(200, 1'b0);
      apply_setup(8'd1, 8'd7, 16'd65535);
      run_phase(120, 1'b0);
      apply_setup(8'd255, 8'd3, 16'd0);
      run_phase(120, 1'b0);
      apply_setup(8'd6, 8'd5, 16'd2000);
      hold_asked++;
      run_phase(200, 1'b0);
      apply_setup(8'd128, 8'd128, 16'd65535);
      run_phase(120, 1'b0);
      apply_setup(8'd2, 8'd2, 16'd500);
      run_phase(180, 1'b1);
      apply_setup(8'd8, 8'd8, 16'($urandom));
      no_idle = 1'b1;
      run_phase(180, 1'b0);

      settle_block();
      if (mismatches == 0 && expected_values.size() == 0)
         $display("bicubic_image_resampler test passed");
      else
         $display("bicubic_image_resampler test failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/bir_pkg.sv
sv/bir_req_if.sv
sv/bir_rsp_if.sv
sv/bir_csr_if.sv
sv/bir_cubic.sv
sv/bir_datapath.sv
sv/bir_ctrl.sv
sv/bicubic_image_resampler.sv
bench/bicubic_image_resampler_tb.sv
